>>> hdl/rcts_pkg.sv
// Shared types, constants and the sensor evaluation function of the conveyor transfer sequencer.
`default_nettype none
package rcts_pkg;

  localparam int POLL_W   = 8;
  localparam int SETTLE_W = 10;
  localparam int CENTER_W = 8;
  localparam int HOLD_W   = 12;
  localparam int DELAY_W  = 12;
  localparam int JOB_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [POLL_W-1:0]   POLL_RESET   = POLL_W'(2);
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(10);
  localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(50);
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(200);

  localparam logic [CFG_IDX_W-1:0] CFG_POLL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = CFG_IDX_W'(3);

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_U_SET    = 4'd1,
    PH_U_SETTLE = 4'd2,
    PH_U_CLEAR  = 4'd3,
    PH_L_ENTRY  = 4'd4,
    PH_L_PASS   = 4'd5,
    PH_CENTER   = 4'd6,
    PH_HOLDOFF  = 4'd7
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [DELAY_W-1:0]  delay_count;
    logic [CENTER_W-1:0] center_count;
    logic [POLL_W-1:0]   poll_count;
    logic                done;
  } seq_st_t;

  typedef struct packed {
    logic [POLL_W-1:0]   poll_period;
    logic [SETTLE_W-1:0] settle_ticks;
    logic [CENTER_W-1:0] center_limit;
    logic [HOLD_W-1:0]   holdoff_ticks;
  } seq_cfg_t;

  // Sensor check with zero-time transitions; the longest chain is three hops.
  function automatic seq_st_t evaluate(seq_st_t s, logic entry, logic far, seq_cfg_t c);
    seq_st_t r;
    logic    stop;
    r    = s;
    stop = 1'b0;
    for (int g = 0; g < 4; g++) begin
      if (!stop) begin
        case (r.phase)
          PH_U_SET: begin
            if (!entry) begin
              r.poll_count = c.poll_period;
              stop = 1'b1;
            end else if (c.settle_ticks == '0) begin
              r.phase = PH_U_CLEAR;
            end else begin
              r.phase       = PH_U_SETTLE;
              r.delay_count = DELAY_W'(c.settle_ticks);
              stop = 1'b1;
            end
          end
          PH_U_CLEAR: begin
            stop = 1'b1;
            if (entry) begin
              r.poll_count = c.poll_period;
            end else begin
              r.phase       = PH_HOLDOFF;
              r.delay_count = DELAY_W'(c.holdoff_ticks);
              if (c.holdoff_ticks == '0) begin
                r.phase = PH_IDLE;
                r.done  = 1'b1;
              end
            end
          end
          PH_L_ENTRY: begin
            if (!entry) begin
              r.poll_count = c.poll_period;
              stop = 1'b1;
            end else begin
              r.phase = PH_L_PASS;
            end
          end
          PH_L_PASS: begin
            if (entry && !far) begin
              r.poll_count = c.poll_period;
              stop = 1'b1;
            end else begin
              r.phase        = PH_CENTER;
              r.center_count = c.center_limit;
            end
          end
          PH_CENTER: begin
            stop = 1'b1;
            if (far || r.center_count == '0) begin
              r.phase       = PH_HOLDOFF;
              r.delay_count = DELAY_W'(c.holdoff_ticks);
              if (c.holdoff_ticks == '0) begin
                r.phase = PH_IDLE;
                r.done  = 1'b1;
              end
            end else begin
              r.center_count = r.center_count - CENTER_W'(1);
            end
          end
          default: stop = 1'b1;
        endcase
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rcts_if.sv
// Handshake channel interfaces: input items, result items and register writes.
`default_nettype none
interface rcts_in_if;
  import rcts_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [JOB_W-1:0] job;
  logic             sensor_left;
  logic             sensor_right;
  modport source (output valid, operation, job, sensor_left, sensor_right, input ready);
  modport sink   (input valid, operation, job, sensor_left, sensor_right, output ready);
endinterface

interface rcts_out_if;
  logic valid;
  logic ready;
  logic drive_left;
  logic drive_right;
  logic busy_res;
  logic done_res;
  modport source (output valid, drive_left, drive_right, busy_res, done_res, input ready);
  modport sink   (input valid, drive_left, drive_right, busy_res, done_res, output ready);
endinterface

interface rcts_cfg_if;
  import rcts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/roller_conveyor_transfer_sequencer_core.sv
// Top level of the roller conveyor transfer sequencer.
// The result of an item is on the output register in the cycle after its beat.
// Throughput: one item per clock unless a result stalls; the state update and the sensor checks
// are one combinational pass between the state registers and the output register.
// The input side stalls only while a result waits in the output register and is not taken.
// Reset (rst, synchronous): idle phase, counters zero, registers at their defaults.
`default_nettype none
module roller_conveyor_transfer_sequencer_core (
  input wire logic clk,
  input wire logic rst,
  rcts_in_if.sink    items,
  rcts_out_if.source results,
  rcts_cfg_if.sink   cfg
);
  import rcts_pkg::*;

  logic [POLL_W-1:0]   poll_ticks;
  logic [SETTLE_W-1:0] settle_ticks;
  logic [CENTER_W-1:0] center_limit;
  logic [HOLD_W-1:0]   holdoff_ticks;

  seq_st_t          st;
  logic [JOB_W-1:0] active_job;

  seq_st_t          st_next;
  logic [JOB_W-1:0] active_job_next;
  seq_cfg_t         ccfg;
  logic             in_ready;
  logic             accept;
  logic             out_valid;
  logic             drive_left, drive_right, busy_res, done_res;
  logic             entry, far, running;
  logic [JOB_W-1:0] sel_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_ticks    <= POLL_RESET;
      settle_ticks  <= SETTLE_RESET;
      center_limit  <= CENTER_RESET;
      holdoff_ticks <= HOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_POLL:   poll_ticks    <= cfg.data[POLL_W-1:0];
        CFG_SETTLE: settle_ticks  <= cfg.data[SETTLE_W-1:0];
        CFG_CENTER: center_limit  <= cfg.data[CENTER_W-1:0];
        CFG_HOLD:   holdoff_ticks <= cfg.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ccfg.poll_period   = (poll_ticks == '0) ? POLL_W'(1) : poll_ticks;
    ccfg.settle_ticks  = settle_ticks;
    ccfg.center_limit  = center_limit;
    ccfg.holdoff_ticks = holdoff_ticks;
  end

  assign in_ready    = !out_valid || results.ready;
  assign items.ready = in_ready;
  assign accept      = items.valid && in_ready;

  // A start in the idle phase picks the job from the beat; otherwise the running job is used.
  assign sel_job = (items.operation == OP_START && st.phase == PH_IDLE) ? items.job
                                                                         : active_job;
  assign entry = sel_job[1] ? items.sensor_right : items.sensor_left;
  assign far   = sel_job[1] ? items.sensor_left  : items.sensor_right;

  always_comb begin
    st_next         = st;
    st_next.done    = 1'b0;
    active_job_next = active_job;
    if (items.operation == OP_START) begin
      if (st.phase == PH_IDLE) begin
        active_job_next = items.job;
        if (!items.job[0]) begin
          st_next.phase = entry ? PH_U_CLEAR : PH_U_SET;
        end else begin
          st_next.phase = PH_L_ENTRY;
        end
        st_next = evaluate(st_next, entry, far, ccfg);
      end
    end else begin
      case (st.phase)
        PH_IDLE: ;
        PH_U_SET, PH_U_CLEAR, PH_L_ENTRY, PH_L_PASS: begin
          if (st.poll_count > POLL_W'(1)) begin
            st_next.poll_count = st.poll_count - POLL_W'(1);
          end else begin
            st_next.poll_count = '0;
            st_next = evaluate(st_next, entry, far, ccfg);
          end
        end
        PH_U_SETTLE: begin
          if (st.delay_count > DELAY_W'(1)) begin
            st_next.delay_count = st.delay_count - DELAY_W'(1);
          end else begin
            st_next.delay_count = '0;
            st_next.phase       = PH_U_CLEAR;
            st_next = evaluate(st_next, entry, far, ccfg);
          end
        end
        PH_CENTER: st_next = evaluate(st_next, entry, far, ccfg);
        PH_HOLDOFF: begin
          if (st.delay_count > DELAY_W'(1)) begin
            st_next.delay_count = st.delay_count - DELAY_W'(1);
          end else begin
            st_next.delay_count = '0;
            st_next.phase       = PH_IDLE;
            st_next.done        = 1'b1;
          end
        end
        default: st_next.phase = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    running     = st_next.phase != PH_IDLE && st_next.phase != PH_HOLDOFF;
    // left-named motor for left unload and right load
    drive_left  = running && (active_job_next[1] ~^ active_job_next[0]);
    drive_right = running && (active_job_next[1] ^ active_job_next[0]);
    busy_res    = st_next.phase != PH_IDLE;
    done_res    = st_next.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '{phase: PH_IDLE, default: '0};
      active_job <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        st         <= st_next;
        active_job <= active_job_next;
      end
      out_valid <= accept || (out_valid && !results.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.drive_left  <= drive_left;
      results.drive_right <= drive_right;
      results.busy_res    <= busy_res;
      results.done_res    <= done_res;
    end
  end

  assign results.valid = out_valid;

endmodule
`default_nettype wire

>>> hdl/rcts_checker.sv
// Port-level checks of the conveyor transfer sequencer and their bind.
`default_nettype none
module rcts_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic drive_left,
  input wire logic drive_right,
  input wire logic busy_res,
  input wire logic done_res
);

  // a waiting result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({drive_left, drive_right, busy_res,
                                                      done_res}))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !drive_left && !drive_right)
    else $error("done reported with job still active");

  a_one_motor: assert property (@(posedge clk) disable iff (rst)
    out_valid && (drive_left || drive_right) |-> busy_res && !(drive_left && drive_right))
    else $error("motor drive inconsistent with busy");

  // with the output free, the input side is never held off
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind roller_conveyor_transfer_sequencer_core rcts_checker u_rcts_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (items.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .drive_left (results.drive_left),
  .drive_right(results.drive_right),
  .busy_res   (results.busy_res),
  .done_res   (results.done_res)
);
`default_nettype wire
